// File: hw/rtl/psf_pkg.sv
// ============================================================================
// psf_pkg
// Shared types and constants of the packet slot FIFO.
// ============================================================================
package psf_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_BYTES = 256;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int INDEX_W = $clog2(SLOT_BYTES);
    localparam int PTR_W   = SLOT_W + 1;
    localparam int LEN_W   = $clog2(SLOT_BYTES + 1);
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = SLOT_W + INDEX_W;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_READ    = 2'd2,
        OP_RELEASE = 2'd3
    } psf_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } psf_status_t;

    // Input beat payload, first field in the highest bits.
    typedef struct packed {
        logic [LEN_W-1:0]   packet_length;
        logic [BYTE_W-1:0]  data_byte;
        logic [INDEX_W-1:0] byte_index;
    } psf_in_t;

    // Result beat payload, first field in the highest bits.
    typedef struct packed {
        logic               is_empty;
        logic               is_full;
        logic [LEN_W-1:0]   head_length;
        logic [BYTE_W-1:0]  read_byte;
        psf_status_t        status;
    } psf_result_t;

    localparam int IN_W      = $bits(psf_in_t);
    localparam int RES_W     = $bits(psf_result_t);
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(SLOT_BYTES);

endpackage

// File: hw/rtl/psf_ram.sv
// ============================================================================
// psf_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered: valid the cycle after a read, held while no read is enabled.
// ============================================================================
module psf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hw/rtl/packet_slot_fifo_unit.sv
// ============================================================================
// packet_slot_fifo_unit
// FIFO of packet slots: bytes are written into the tail slot and committed
// with a length; bytes are read from the head slot and the slot is released.
// ============================================================================
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-----------------------------------
// s_       | in        | s_tvalid/s_tready  | s_tuser: operation; s_tdata: index,
//          |           |                    | data byte, packet length
// m_       | out       | m_tvalid/m_tready  | m_tdata: status, read byte, head
//          |           |                    | length, full flag, empty flag
//
// Each operation runs through the sequencer states in order: ST_IDLE accepts
// the beat and performs the byte access and the pointer update, ST_LEN reads
// the stored length of the (possibly new) head slot from the length memory,
// and ST_DONE loads the result register once the m_ side is free.
// The result register frees the input side: a new beat is taken while an
// earlier result still waits on the m_ side, and only the load of the next
// result waits on m_tready.
// Reset is synchronous and active low; it clears the pointers and the
// handshake state. The memories get no clearing pass.
module packet_slot_fifo_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input beat.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psf_pkg::OP_W-1:0]       s_tuser,  // [1:0] operation
    input  logic [psf_pkg::S_TDATA_W-1:0]  s_tdata,  // byte_index, data_byte,
                                                     // packet_length, zero fill
    // Result beat.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psf_pkg::M_TDATA_W-1:0]  m_tdata   // status, read_byte,
                                                     // head_length, is_full,
                                                     // is_empty, zero fill
);

    // One-hot sequencer: accept, length lookup, result load.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LEN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [psf_pkg::PTR_W-1:0] tail_reg, tail_next;
    logic [psf_pkg::PTR_W-1:0] head_reg, head_next;

    psf_pkg::psf_status_t status_reg, status_next;
    logic                 read_ok_reg, read_ok_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic [psf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    psf_pkg::psf_in_t     in_beat;
    psf_pkg::psf_op_t     op;
    psf_pkg::psf_result_t result;

    logic accept;
    logic full_now;
    logic empty_now;
    logic out_free;

    logic [psf_pkg::SLOT_W-1:0] tail_slot;
    logic [psf_pkg::SLOT_W-1:0] head_slot;

    // Byte memory ports.
    logic                        byte_we;
    logic                        byte_re;
    logic [psf_pkg::ADDR_W-1:0]  byte_waddr;
    logic [psf_pkg::ADDR_W-1:0]  byte_raddr;
    logic [psf_pkg::BYTE_W-1:0]  byte_rdata;

    // Length memory ports.
    logic                        len_we;
    logic                        len_re;
    logic [psf_pkg::LEN_W-1:0]   len_wdata;
    logic [psf_pkg::LEN_W-1:0]   len_rdata;

    assign in_beat   = psf_pkg::psf_in_t'(s_tdata[psf_pkg::IN_W-1:0]);
    assign op        = psf_pkg::psf_op_t'(s_tuser);
    assign tail_slot = tail_reg[psf_pkg::SLOT_W-1:0];
    assign head_slot = head_reg[psf_pkg::SLOT_W-1:0];

    // Wrap bits differ with equal slot numbers when every slot is committed.
    assign empty_now = (tail_reg == head_reg);
    assign full_now  = !empty_now && (tail_slot == head_slot);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Memory requests are issued in the accepting cycle, except the length
    // lookup, which uses the head pointer after this beat moved it.
    always_comb begin
        byte_we    = accept && (op == psf_pkg::OP_WRITE) && !full_now;
        byte_re    = accept && (op == psf_pkg::OP_READ) && !empty_now;
        byte_waddr = {tail_slot, in_beat.byte_index};
        byte_raddr = {head_slot, in_beat.byte_index};

        len_we    = accept && (op == psf_pkg::OP_COMMIT) && !full_now;
        len_wdata = (in_beat.packet_length > psf_pkg::MAX_LEN) ?
                    psf_pkg::MAX_LEN : in_beat.packet_length;
        len_re    = (state_reg == ST_LEN);
    end

    psf_ram #(
        .WIDTH (psf_pkg::BYTE_W),
        .DEPTH (psf_pkg::SLOTS * psf_pkg::SLOT_BYTES)
    ) u_byte_ram (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (in_beat.data_byte),
        .re    (byte_re),
        .raddr (byte_raddr),
        .rdata (byte_rdata)
    );

    psf_ram #(
        .WIDTH (psf_pkg::LEN_W),
        .DEPTH (psf_pkg::SLOTS)
    ) u_len_ram (
        .aclk  (aclk),
        .we    (len_we),
        .waddr (tail_slot),
        .wdata (len_wdata),
        .re    (len_re),
        .raddr (head_slot),
        .rdata (len_rdata)
    );

    // Result fields; the flags reflect the pointers after the operation.
    always_comb begin
        result             = '0;
        result.status      = status_reg;
        result.read_byte   = read_ok_reg ? byte_rdata : '0;
        result.head_length = empty_now ? '0 : len_rdata;
        result.is_full     = full_now;
        result.is_empty    = empty_now;
    end

    always_comb begin
        state_next    = state_reg;
        tail_next     = tail_reg;
        head_next     = head_reg;
        status_next   = status_reg;
        read_ok_next  = read_ok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    status_next  = psf_pkg::STAT_DONE;
                    read_ok_next = 1'b0;
                    case (op)
                        psf_pkg::OP_WRITE: begin
                            if (full_now) begin
                                status_next = psf_pkg::STAT_FULL;
                            end
                        end
                        psf_pkg::OP_COMMIT: begin
                            if (full_now) begin
                                status_next = psf_pkg::STAT_FULL;
                            end else begin
                                tail_next = tail_reg + 1'b1;
                            end
                        end
                        psf_pkg::OP_READ: begin
                            if (empty_now) begin
                                status_next = psf_pkg::STAT_EMPTY;
                            end else begin
                                read_ok_next = 1'b1;
                            end
                        end
                        default: begin
                            if (empty_now) begin
                                status_next = psf_pkg::STAT_EMPTY;
                            end else begin
                                head_next = head_reg + 1'b1;
                            end
                        end
                    endcase
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = psf_pkg::M_TDATA_W'(result);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tail_reg     <= '0;
            head_reg     <= '0;
            read_ok_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tail_reg     <= tail_next;
            head_reg     <= head_next;
            read_ok_reg  <= read_ok_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg  <= status_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: hw/rtl/psf_checker.sv
// ============================================================================
// psf_checker
// Port-level checks on the result beats of the packet slot FIFO.
// ============================================================================
module psf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [psf_pkg::M_TDATA_W-1:0]  m_tdata
);

    psf_pkg::psf_result_t res;

    assign res = psf_pkg::psf_result_t'(m_tdata[psf_pkg::RES_W-1:0]);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res.is_full && res.is_empty))
        else $error("full and empty flagged together");

    // An empty FIFO shows no head length and delivers no byte.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.is_empty |-> res.head_length == '0 && res.read_byte == '0)
        else $error("empty result carries data");

    // A rejected operation leaves the state that caused the rejection.
    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == psf_pkg::STAT_FULL |-> res.is_full)
        else $error("full rejection without full flag");

    a_reject_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == psf_pkg::STAT_EMPTY |-> res.is_empty)
        else $error("empty rejection without empty flag");

endmodule

bind packet_slot_fifo_unit psf_checker u_psf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
